// File: rtl/pn3d_pkg.sv
// Shared types, constants and step codes of the 3D gradient noise block.
`default_nettype none
package pn3d_pkg;

  // Default fixed-point formats.
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF   = 16;

  // Result field width.
  localparam int NOISE_W = 18;

  // Input item commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Sequencer counter and phase lengths.
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] HASH_LAST = CNT_W'(27);
  localparam logic [CNT_W-1:0] MATH_LAST = CNT_W'(37);

  // Table lookup steps, in issue order.
  localparam logic [3:0] LK_CX  = 4'd0;
  localparam logic [3:0] LK_CX1 = 4'd1;
  localparam logic [3:0] LK_A   = 4'd2;
  localparam logic [3:0] LK_A1  = 4'd3;
  localparam logic [3:0] LK_B   = 4'd4;
  localparam logic [3:0] LK_B1  = 4'd5;
  localparam logic [3:0] LK_AA  = 4'd6;
  localparam logic [3:0] LK_BA  = 4'd7;
  localparam logic [3:0] LK_AB  = 4'd8;
  localparam logic [3:0] LK_BB  = 4'd9;
  localparam logic [3:0] LK_AA1 = 4'd10;
  localparam logic [3:0] LK_BA1 = 4'd11;
  localparam logic [3:0] LK_AB1 = 4'd12;
  localparam logic [3:0] LK_BB1 = 4'd13;

  // Multiply steps: three fades of four products each, then seven blends.
  localparam logic [4:0] OP_EASE_X = 5'd0;
  localparam logic [4:0] OP_EASE_Y = 5'd4;
  localparam logic [4:0] OP_EASE_Z = 5'd8;
  localparam logic [4:0] OP_LERP_0 = 5'd12;
  localparam logic [4:0] OP_LERP_1 = 5'd13;
  localparam logic [4:0] OP_LERP_2 = 5'd14;
  localparam logic [4:0] OP_LERP_3 = 5'd15;
  localparam logic [4:0] OP_LERP_4 = 5'd16;
  localparam logic [4:0] OP_LERP_5 = 5'd17;
  localparam logic [4:0] OP_LERP_6 = 5'd18;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HASH = 4'b0010,
    ST_MATH = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       wr;
    logic       hash;
    logic [3:0] idx;
    logic       capture;
    logic       math;
    logic [4:0] op;
    logic       sub;
    logic       finish;
  } ctrl_t;

endpackage
`default_nettype wire

// File: rtl/pn3d_req_if.sv
// Request channel: load or evaluate items.
`default_nettype none
interface pn3d_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [7:0]         table_index;
  logic [7:0]         table_value;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] z_coord;

  modport source (output valid, cmd, table_index, table_value, x_coord, y_coord, z_coord,
                  input ready);
  modport sink (input valid, cmd, table_index, table_value, x_coord, y_coord, z_coord,
                output ready);
endinterface
`default_nettype wire

// File: rtl/pn3d_rsp_if.sv
// Result channel: one noise value per evaluate item.
`default_nettype none
interface pn3d_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pn3d_pkg::NOISE_W-1:0]    noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface
`default_nettype wire

// File: rtl/pn3d_ctrl.sv
// Controller state machine: sequences lookups, multiplies and the result transfer.
`default_nettype none
module pn3d_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_cmd,
  input  wire logic             out_ready,
  output logic                  in_ready,
  output logic                  out_valid,
  output pn3d_pkg::ctrl_t       ctl
);

  pn3d_pkg::state_t                 state, state_next;
  logic [pn3d_pkg::CNT_W-1:0]       cnt, cnt_next;
  logic                             out_valid_next;
  logic                             accept;

  // Items are taken only between evaluations.
  assign in_ready = (state == pn3d_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Commands to the datapath.
  always_comb begin
    ctl         = '0;
    ctl.load    = accept && (in_cmd == pn3d_pkg::CMD_EVAL);
    ctl.wr      = accept && (in_cmd == pn3d_pkg::CMD_LOAD);
    ctl.hash    = (state == pn3d_pkg::ST_HASH);
    ctl.idx     = cnt[4:1];
    ctl.capture = cnt[0];
    ctl.math    = (state == pn3d_pkg::ST_MATH);
    ctl.op      = cnt[5:1];
    ctl.sub     = cnt[0];
    ctl.finish  = (state == pn3d_pkg::ST_DONE) && (!out_valid || out_ready);
  end

  // Next state and step counter.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      pn3d_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (ctl.load) state_next = pn3d_pkg::ST_HASH;
      end
      pn3d_pkg::ST_HASH: begin
        if (cnt == pn3d_pkg::HASH_LAST) begin
          cnt_next   = '0;
          state_next = pn3d_pkg::ST_MATH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      pn3d_pkg::ST_MATH: begin
        if (cnt == pn3d_pkg::MATH_LAST) begin
          cnt_next   = '0;
          state_next = pn3d_pkg::ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      pn3d_pkg::ST_DONE: begin
        if (ctl.finish) state_next = pn3d_pkg::ST_IDLE;
      end
      default: state_next = pn3d_pkg::ST_IDLE;
    endcase
  end

  // The output register is full from finish until its transfer.
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (ctl.finish) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pn3d_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pn3d_datapath.sv
// Datapath: permutation memory, hash registers, corner gradients and a shared multiplier.
`default_nettype none
module pn3d_datapath #(
  parameter int COORD_FRAC_BITS = pn3d_pkg::COORD_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = pn3d_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire pn3d_pkg::ctrl_t                      ctl,
  input  wire logic [7:0]                           table_index,
  input  wire logic [7:0]                           table_value,
  input  wire logic signed [31:0]                   x_coord,
  input  wire logic signed [31:0]                   y_coord,
  input  wire logic signed [31:0]                   z_coord,
  output logic signed [pn3d_pkg::NOISE_W-1:0]       noise_value
);

  localparam int F   = COORD_FRAC_BITS;
  localparam int W   = F + 6;
  localparam int PW  = 2 * W;
  localparam int SW  = W + OUT_FRAC_BITS;
  localparam int LSH = (OUT_FRAC_BITS >= F) ? OUT_FRAC_BITS - F : 0;
  localparam int RSH = (OUT_FRAC_BITS >= F) ? 0 : F - OUT_FRAC_BITS;
  localparam logic signed [W-1:0] ONE_Q   = W'(1) << F;
  localparam logic signed [W-1:0] TEN_Q   = W'(10) << F;
  localparam logic signed [W-1:0] FIFTN_Q = W'(15) << F;
  localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (pn3d_pkg::NOISE_W - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic [7:0]          mem [0:255];
  logic [7:0]          rd_data;
  logic [7:0]          rd_addr;
  logic [7:0]          cx, cy, cz;
  logic [7:0]          ha, hb, haa, hab, hba, hbb;
  logic signed [W-1:0] fx, fy, fz, ex, ey, ez;
  logic signed [W-1:0] c [0:7];
  logic signed [W-1:0] nfx, nfy, nfz;
  logic signed [W-1:0] mul_t, mul_y, mul_a, add_v, diff, res;
  logic signed [PW-1:0] prod, prod_c;
  logic signed [SW-1:0] ext, scaled;
  logic [2:0]          cidx;

  // Gradient dot product from the low four hash bits.
  function automatic logic signed [W-1:0] corner(input logic [3:0] h,
                                                 input logic signed [W-1:0] dx,
                                                 input logic signed [W-1:0] dy,
                                                 input logic signed [W-1:0] dz);
    logic signed [W-1:0] p, q;
    p = (h < 4'd8) ? dx : dy;
    q = (h < 4'd4) ? dy : ((h == 4'd12 || h == 4'd14) ? dx : dz);
    if (h[0]) p = -p;
    if (h[1]) q = -q;
    return p + q;
  endfunction

  // Fractions of the incoming point.
  assign nfx = W'({1'b0, x_coord[F-1:0]});
  assign nfy = W'({1'b0, y_coord[F-1:0]});
  assign nfz = W'({1'b0, z_coord[F-1:0]});

  // Lookup address for each step; all sums wrap at 256.
  always_comb begin
    case (ctl.idx)
      pn3d_pkg::LK_CX:  rd_addr = cx;
      pn3d_pkg::LK_CX1: rd_addr = cx + 8'd1;
      pn3d_pkg::LK_A:   rd_addr = ha + cy;
      pn3d_pkg::LK_A1:  rd_addr = ha + cy + 8'd1;
      pn3d_pkg::LK_B:   rd_addr = hb + cy;
      pn3d_pkg::LK_B1:  rd_addr = hb + cy + 8'd1;
      pn3d_pkg::LK_AA:  rd_addr = haa + cz;
      pn3d_pkg::LK_BA:  rd_addr = hba + cz;
      pn3d_pkg::LK_AB:  rd_addr = hab + cz;
      pn3d_pkg::LK_BB:  rd_addr = hbb + cz;
      pn3d_pkg::LK_AA1: rd_addr = haa + cz + 8'd1;
      pn3d_pkg::LK_BA1: rd_addr = hba + cz + 8'd1;
      pn3d_pkg::LK_AB1: rd_addr = hab + cz + 8'd1;
      pn3d_pkg::LK_BB1: rd_addr = hbb + cz + 8'd1;
      default:          rd_addr = cx;
    endcase
  end

  // Permutation memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr) mem[table_index] <= table_value;
    rd_data <= mem[rd_addr];
  end

  // Corner number of a final hash lookup: bit 0 picks x-1, bit 1 y-1, bit 2 z-1.
  assign cidx = 3'(ctl.idx - pn3d_pkg::LK_AA);

  // Operand selection for each multiply step.
  always_comb begin
    mul_t = fx;
    mul_y = ex;
    mul_a = '0;
    add_v = '0;
    unique case (ctl.op) inside
      [pn3d_pkg::OP_EASE_X : pn3d_pkg::OP_EASE_Y - 5'd1]: begin
        mul_t = fx;
        mul_y = ex;
        add_v = (ctl.op == pn3d_pkg::OP_EASE_X) ? TEN_Q : '0;
      end
      [pn3d_pkg::OP_EASE_Y : pn3d_pkg::OP_EASE_Z - 5'd1]: begin
        mul_t = fy;
        mul_y = ey;
        add_v = (ctl.op == pn3d_pkg::OP_EASE_Y) ? TEN_Q : '0;
      end
      [pn3d_pkg::OP_EASE_Z : pn3d_pkg::OP_LERP_0 - 5'd1]: begin
        mul_t = fz;
        mul_y = ez;
        add_v = (ctl.op == pn3d_pkg::OP_EASE_Z) ? TEN_Q : '0;
      end
      pn3d_pkg::OP_LERP_0: begin mul_t = ex; mul_a = c[0]; mul_y = c[1]; add_v = c[0]; end
      pn3d_pkg::OP_LERP_1: begin mul_t = ex; mul_a = c[2]; mul_y = c[3]; add_v = c[2]; end
      pn3d_pkg::OP_LERP_2: begin mul_t = ex; mul_a = c[4]; mul_y = c[5]; add_v = c[4]; end
      pn3d_pkg::OP_LERP_3: begin mul_t = ex; mul_a = c[6]; mul_y = c[7]; add_v = c[6]; end
      pn3d_pkg::OP_LERP_4: begin mul_t = ey; mul_a = c[0]; mul_y = c[2]; add_v = c[0]; end
      pn3d_pkg::OP_LERP_5: begin mul_t = ey; mul_a = c[4]; mul_y = c[6]; add_v = c[4]; end
      pn3d_pkg::OP_LERP_6: begin mul_t = ez; mul_a = c[0]; mul_y = c[4]; add_v = c[0]; end
      default: begin mul_t = fx; end
    endcase
  end

  // Shared multiplier; the product is registered before the shift and add.
  assign diff   = mul_y - mul_a;
  assign prod_c = mul_t * diff;
  assign res    = W'(prod >>> F) + add_v;

  // Output rescale and saturation.
  assign ext    = SW'(c[0]);
  assign scaled = (ext <<< LSH) >>> RSH;

  always_ff @(posedge clk) begin
    // Latch the point at the start of an evaluation.
    if (ctl.load) begin
      cx <= x_coord[F+7:F];
      cy <= y_coord[F+7:F];
      cz <= z_coord[F+7:F];
      fx <= nfx;
      fy <= nfy;
      fz <= nfz;
      ex <= W'(6) * nfx - FIFTN_Q;
      ey <= W'(6) * nfy - FIFTN_Q;
      ez <= W'(6) * nfz - FIFTN_Q;
    end
    // Capture lookup results.
    if (ctl.hash && ctl.capture) begin
      case (ctl.idx)
        pn3d_pkg::LK_CX:  ha  <= rd_data;
        pn3d_pkg::LK_CX1: hb  <= rd_data;
        pn3d_pkg::LK_A:   haa <= rd_data;
        pn3d_pkg::LK_A1:  hab <= rd_data;
        pn3d_pkg::LK_B:   hba <= rd_data;
        pn3d_pkg::LK_B1:  hbb <= rd_data;
        default: c[cidx] <= corner(rd_data[3:0],
                                   cidx[0] ? fx - ONE_Q : fx,
                                   cidx[1] ? fy - ONE_Q : fy,
                                   cidx[2] ? fz - ONE_Q : fz);
      endcase
    end
    // Each step first registers the product, then writes the shifted and added result back.
    if (ctl.math) begin
      if (!ctl.sub) begin
        prod <= prod_c;
      end else begin
        unique case (ctl.op) inside
          [pn3d_pkg::OP_EASE_X : pn3d_pkg::OP_EASE_Y - 5'd1]: ex <= res;
          [pn3d_pkg::OP_EASE_Y : pn3d_pkg::OP_EASE_Z - 5'd1]: ey <= res;
          [pn3d_pkg::OP_EASE_Z : pn3d_pkg::OP_LERP_0 - 5'd1]: ez <= res;
          pn3d_pkg::OP_LERP_0, pn3d_pkg::OP_LERP_4, pn3d_pkg::OP_LERP_6: c[0] <= res;
          pn3d_pkg::OP_LERP_1: c[2] <= res;
          pn3d_pkg::OP_LERP_2, pn3d_pkg::OP_LERP_5: c[4] <= res;
          pn3d_pkg::OP_LERP_3: c[6] <= res;
          default: prod <= prod;
        endcase
      end
    end
    // Load the result register.
    if (ctl.finish) begin
      if (scaled > SAT_HI)      noise_value <= pn3d_pkg::NOISE_W'(SAT_HI);
      else if (scaled < SAT_LO) noise_value <= pn3d_pkg::NOISE_W'(SAT_LO);
      else                      noise_value <= pn3d_pkg::NOISE_W'(scaled);
    end
  end

endmodule
`default_nettype wire

// File: rtl/perlin_noise_3d.sv
// Top level of the 3D improved gradient noise block.
//
// The request channel carries two kinds of transfer. A load (cmd 0) writes one
// byte of the 256-entry permutation table in the cycle it is accepted and gives
// no result. An evaluate (cmd 1) takes a signed fixed-point point and gives one
// saturated 18-bit noise value on the result channel. Software loads every
// table entry before the first evaluation.
// An evaluation first makes fourteen dependent lookups through the registered
// read port of the table memory, then nineteen multiplies (three quintic fades
// and seven blends) on one shared multiplier, and then loads the output
// register. Loads are taken one per cycle while the block is idle; the next
// item is taken right after the result register is loaded. A stalled receiver
// keeps the result in the output register; a finished evaluation then waits
// until that register is free. Reset empties the output register and returns
// the controller to idle; the table keeps its contents.
`default_nettype none
module perlin_noise_3d #(
  parameter int COORD_FRAC_BITS = pn3d_pkg::COORD_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = pn3d_pkg::OUT_FRAC_BITS_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  pn3d_req_if.sink        request,
  pn3d_rsp_if.source      result
);

  pn3d_pkg::ctrl_t ctl;
  logic            in_ready;
  logic            out_valid;

  pn3d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_cmd    (request.cmd),
    .out_ready (result.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  pn3d_datapath #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .OUT_FRAC_BITS   (OUT_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .ctl         (ctl),
    .table_index (request.table_index),
    .table_value (request.table_value),
    .x_coord     (request.x_coord),
    .y_coord     (request.y_coord),
    .z_coord     (request.z_coord),
    .noise_value (result.noise_value)
  );

  assign request.ready = in_ready;
  assign result.valid  = out_valid;

  // An accepted evaluation closes the request channel in the next cycle.
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready && request.cmd == pn3d_pkg::CMD_EVAL) |=> !request.ready)
    else $error("request channel open after evaluate transfer");

  // A result appears only after the datapath loaded it.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(ctl.finish))
    else $error("result valid without finish");

  // Finishing never overlaps with taking a new item.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> !request.ready)
    else $error("finish while request channel open");

endmodule
`default_nettype wire

// File: bench/tb_perlin_noise_3d.sv
// Self-checking testbench for the 3D gradient noise block.
`default_nettype none
module tb_perlin_noise_3d;

  logic clk = 1'b0;
  logic rst = 1'b1;
  pn3d_req_if request ();
  pn3d_rsp_if result ();

  perlin_noise_3d DUT (
    .clk(clk),
    .rst(rst),
    .request(request),
    .result(result)
  );

  always #5 clk = ~clk;

  localparam int FRAC = pn3d_pkg::COORD_FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 <<< FRAC;

  // Predictor state: its own copy of the permutation table.
  logic [7:0] perm_copy [256];
  logic signed [pn3d_pkg::NOISE_W-1:0] noise_queue [$];
  int errors = 0;
  int evals_sent = 0;
  int loads_sent = 0;
  int results_seen = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;

  // Floor shift of an exact product.
  function automatic longint fx_mul(longint a, longint b);
    fx_mul = (a * b) >>> FRAC;
  endfunction

  function automatic longint fade(longint t);
    longint r;
    r = 6 * t - 15 * ONE;
    r = fx_mul(t, r) + 10 * ONE;
    r = fx_mul(t, r);
    r = fx_mul(t, r);
    fade = fx_mul(t, r);
  endfunction

  function automatic longint mix(longint t, longint a, longint b);
    mix = a + fx_mul(t, b - a);
  endfunction

  // Gradient dot product selected by the low four hash bits.
  function automatic longint grad(logic [7:0] hash, longint dx, longint dy, longint dz);
    logic [3:0] h;
    longint p, q;
    h = hash[3:0];
    p = (h < 8) ? dx : dy;
    q = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : dz);
    grad = (h[0] ? -p : p) + (h[1] ? -q : q);
  endfunction

  function automatic logic signed [pn3d_pkg::NOISE_W-1:0] noise_at(logic [31:0] x,
                                                                    logic [31:0] y,
                                                                    logic [31:0] z);
    logic [7:0] cx, cy, cz, a, aa, ab, b, ba, bb;
    longint fx, fy, fz, gx, gy, gz, u, v, w, l0, l1, l2, l3, r;
    cx = x[FRAC +: 8];
    cy = y[FRAC +: 8];
    cz = z[FRAC +: 8];
    fx = longint'(x[FRAC-1:0]);
    fy = longint'(y[FRAC-1:0]);
    fz = longint'(z[FRAC-1:0]);
    gx = fx - ONE;
    gy = fy - ONE;
    gz = fz - ONE;
    u = fade(fx);
    v = fade(fy);
    w = fade(fz);
    a = perm_copy[cx] + cy;
    aa = perm_copy[a] + cz;
    ab = perm_copy[8'(a + 1)] + cz;
    b = perm_copy[8'(cx + 1)] + cy;
    ba = perm_copy[b] + cz;
    bb = perm_copy[8'(b + 1)] + cz;
    l0 = mix(u, grad(perm_copy[aa], fx, fy, fz), grad(perm_copy[ba], gx, fy, fz));
    l1 = mix(u, grad(perm_copy[ab], fx, gy, fz), grad(perm_copy[bb], gx, gy, fz));
    l2 = mix(u, grad(perm_copy[8'(aa + 1)], fx, fy, gz),
             grad(perm_copy[8'(ba + 1)], gx, fy, gz));
    l3 = mix(u, grad(perm_copy[8'(ab + 1)], fx, gy, gz),
             grad(perm_copy[8'(bb + 1)], gx, gy, gz));
    r = mix(w, mix(v, l0, l1), mix(v, l2, l3));
    if (r < -131072) r = -131072;
    if (r > 131071) r = 131071;
    noise_at = pn3d_pkg::NOISE_W'(r);
  endfunction

  // Send one item; the expectation is recorded at the transfer.
  task automatic send_item(logic cmd, logic [7:0] idx, logic [7:0] val,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      request.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    request.valid <= 1'b1;
    request.cmd <= cmd;
    request.table_index <= idx;
    request.table_value <= val;
    request.x_coord <= x;
    request.y_coord <= y;
    request.z_coord <= z;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    if (cmd == pn3d_pkg::CMD_LOAD) begin
      perm_copy[idx] = val;
      loads_sent++;
    end else begin
      noise_queue.push_back(noise_at(x, y, z));
      evals_sent++;
    end
  endtask

  task automatic send_eval(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_item(pn3d_pkg::CMD_EVAL, 8'($urandom), 8'($urandom), x, y, z);
  endtask

  task automatic send_load(logic [7:0] idx, logic [7:0] val);
    send_item(pn3d_pkg::CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
  endtask

  // The request channel goes quiet until every result is back.
  task automatic wait_drained();
    request.valid <= 1'b0;
    while (noise_queue.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Fill the whole table before any evaluation, first with a shuffle.
  task automatic test_table_fill();
    logic [7:0] shuffle [256];
    int j;
    logic [7:0] t;
    for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = shuffle[i];
      shuffle[i] = shuffle[j];
      shuffle[j] = t;
    end
    for (int i = 0; i < 256; i++) send_load(8'(i), shuffle[i]);
  endtask

  // Coordinate extremes, lattice points and wrapping cells.
  task automatic test_directed();
    send_eval(32'h0, 32'h0, 32'h0);
    send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_eval(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h00FF_8000);
    send_eval(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_eval(32'h00FF_7FFF, 32'h8000_8000, 32'h7FFF_0001);
    send_eval(32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_AAAA);
    send_eval(32'hAAAA_5555, 32'h0000_0001, 32'hFFFF_FFFE);
    // Entry 0 takes each value from 0 to 15 in turn, each followed by an evaluation in cell 0.
    for (int h = 0; h < 16; h++) begin
      send_load(8'h00, 8'(h));
      send_eval(32'h0000_4000, 32'h0000_C000, 32'h0000_7000);
    end
    wait_drained();
  endtask

  // Random evaluations with occasional table rewrites.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_load(8'($urandom), 8'($urandom));
      else if ($urandom_range(0, 4) == 0)
        send_eval($urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF : $urandom,
                  32'($urandom_range(0, 3) << FRAC) | 32'($urandom_range(0, 65535)),
                  $urandom_range(0, 1) ? 32'h8000_0000 : $urandom);
      else send_eval($urandom, $urandom, $urandom);
    end
  endtask

  // Result side: random stalls if idle_on; check against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        results_seen++;
        if (noise_queue.size() == 0) begin
          $error("noise_value: unexpected result %0d", result.noise_value);
          errors++;
        end else begin
          if (result.noise_value !== noise_queue[0]) begin
            $error("noise_value: expected %0d actual %0d", noise_queue[0], result.noise_value);
            errors++;
          end
          void'(noise_queue.pop_front());
        end
      end
      result.ready <= !(idle_on && $urandom_range(0, 7) == 0);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("perlin_noise_3d: mismatch");
      $finish;
    end
  end

  initial begin
    request.valid = 1'b0;
    request.cmd = pn3d_pkg::CMD_LOAD;
    request.table_index = '0;
    request.table_value = '0;
    request.x_coord = '0;
    request.y_coord = '0;
    request.z_coord = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_table_fill();
    test_directed();
    test_random(1000);
    idle_on = 1'b0;
    test_random(350);
    wait_drained();
    $display("Covered %0d table loads and %0d noise evaluations, %0d results checked.",
             loads_sent, evals_sent, results_seen);
    if (errors == 0) $display("perlin_noise_3d: match");
    else $display("perlin_noise_3d: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

// File: perlin_noise_3d.f
rtl/pn3d_pkg.sv
rtl/pn3d_req_if.sv
rtl/pn3d_rsp_if.sv
rtl/pn3d_ctrl.sv
rtl/pn3d_datapath.sv
rtl/perlin_noise_3d.sv
bench/tb_perlin_noise_3d.sv
